[sv/pulse_duration_item_packer_defines.svh]
// pulse_duration_item_packer_defines.svh: assertion macros for the pulse item packer
// no dependencies; included by the checker file
`ifndef PULSE_DURATION_ITEM_PACKER_DEFINES_SVH
`define PULSE_DURATION_ITEM_PACKER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PDIP_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PDIP_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pdip_pkg.sv]
// pdip_pkg: constants, widths and controller/datapath interface types
// for the pulse duration item packer; no dependencies
package pdip_pkg;

  localparam int DUR_W              = 16;
  localparam int CFG_W              = 10;
  localparam int TICKS_W            = 15;
  localparam int MAX_CHUNK_TICKS_DEF = 32767;
  localparam int CHUNKS_CAP         = 80;
  localparam logic [CFG_W-1:0] TPT_RESET = 10'd10;

  // microseconds times ticks per ten microseconds
  localparam int PROD_W      = DUR_W + CFG_W;
  // exact divide by ten for values up to 32 bits: (x * RECIP_10) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;
  localparam int SCALED_W    = PROD_W + 32;
  localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;

  localparam int IN_TDATA_W  = DUR_W;
  localparam int OUT_TDATA_W = 2 * (TICKS_W + 1);

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_div;
    logic do_chunk;
    logic do_pad;
  } pdip_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic chunk_done;
    logic half_pending;
    logic is_last;
  } pdip_sts_t;

endpackage

[sv/pdip_ctrl.sv]
// pdip_ctrl: sequencing state machine for the pulse duration item packer
// depends on pdip_pkg for the command and status types
module pdip_ctrl
  import pdip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  pdip_sts_t sts,
  output pdip_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CHUNK,
    ST_PAD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.do_div = 1'b1;
        state_nxt  = ST_CHUNK;
      end
      ST_CHUNK: begin
        if (sts.out_free) begin
          cmd.do_chunk = 1'b1;
          if (sts.chunk_done) begin
            // a chunk stored as first half on the last input needs padding
            if (sts.is_last && !sts.half_pending) begin
              state_nxt = ST_PAD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_PAD: begin
        if (sts.out_free) begin
          cmd.do_pad = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule

[sv/pdip_dpath.sv]
// pdip_dpath: tick conversion, chunk splitting, half pairing and output register
// depends on pdip_pkg for widths, constants and command/status types
module pdip_dpath
  import pdip_pkg::*;
#(
  parameter int MAX_CHUNK_TICKS = MAX_CHUNK_TICKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   cfg_valid,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  pdip_cmd_t              cmd,
  output pdip_sts_t              sts
);

  localparam int CAP   = CHUNKS_CAP * MAX_CHUNK_TICKS;
  localparam int CAP_W = $clog2(CAP + 1);

  logic [CFG_W-1:0]       tpt_r;
  logic                   level_r;
  logic                   last_r;
  logic [DUR_W-1:0]       mag_r;
  logic [PROD_W-1:0]      prod_r;
  logic [CAP_W-1:0]       rem_r;
  logic                   half_pending_r;
  logic                   pend_level_r;
  logic [TICKS_W-1:0]     pend_ticks_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  logic [SCALED_W-1:0]    scaled;
  logic [QUOT_W-1:0]      quot;
  logic [CAP_W-1:0]       ticks_capped;
  logic                   chunk_done;
  logic [TICKS_W-1:0]     chunk;
  logic                   out_free;

  // divide by ten through the reciprocal, then saturate
  assign scaled       = SCALED_W'(prod_r) * SCALED_W'(RECIP_10);
  assign quot         = scaled[RECIP_SHIFT +: QUOT_W];
  assign ticks_capped = (quot > QUOT_W'(CAP)) ? CAP_W'(CAP) : CAP_W'(quot);

  // next chunk of the remaining ticks
  assign chunk_done = (rem_r <= CAP_W'(MAX_CHUNK_TICKS));
  assign chunk      = chunk_done ? TICKS_W'(rem_r) : TICKS_W'(MAX_CHUNK_TICKS);

  assign out_free   = !out_valid_r || out_tready;

  assign sts.out_free     = out_free;
  assign sts.chunk_done   = chunk_done;
  assign sts.half_pending = half_pending_r;
  assign sts.is_last      = last_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpt_r <= TPT_RESET;
    end else if (cfg_valid) begin
      tpt_r <= cfg_data;
    end
  end

  // input capture, scaling and chunk countdown
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      level_r <= ~in_tdata[DUR_W-1];
      last_r  <= in_tlast;
      mag_r   <= in_tdata[DUR_W-1] ? (~in_tdata + DUR_W'(1)) : in_tdata;
    end
    if (cmd.do_mul) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(tpt_r);
    end
    if (cmd.do_div) begin
      rem_r <= ticks_capped;
    end else if (cmd.do_chunk) begin
      rem_r <= rem_r - CAP_W'(chunk);
    end
  end

  // pending first half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_pending_r <= 1'b0;
    end else if (cmd.do_chunk) begin
      half_pending_r <= ~half_pending_r;
    end else if (cmd.do_pad) begin
      half_pending_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_chunk && !half_pending_r) begin
      pend_level_r <= level_r;
      pend_ticks_r <= chunk;
    end
  end

  // output register, reloaded as soon as the held transaction leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.do_chunk && half_pending_r) || cmd.do_pad) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_chunk && half_pending_r) begin
      out_data_r <= {chunk, level_r, pend_ticks_r, pend_level_r};
      out_last_r <= last_r && chunk_done;
    end else if (cmd.do_pad) begin
      out_data_r <= {TICKS_W'(0), 1'b0, pend_ticks_r, pend_level_r};
      out_last_r <= 1'b1;
    end
  end

endmodule

[sv/pulse_duration_item_packer.sv]
// pulse_duration_item_packer: top level of the pulse item packer
// depends on pdip_pkg, pdip_ctrl and pdip_dpath
//
//  channel | direction | handshake            | contents
//  in_     | input     | in_tvalid/in_tready  | tdata duration, tlast last
//  out_    | output    | out_tvalid/out_tready| tdata two halves, tlast final_item
//  cfg_    | input     | cfg_valid/cfg_ready  | ticks_per_ten_us
//
// one duration at a time: accept, multiply, divide by ten, then split into chunks
// of up to MAX_CHUNK_TICKS ticks, plus a padding half on a last input with an odd
// half left; the chunk loop stalls while the output register is full.
// rst_n is synchronous; the register returns to 10 and no half is pending.
// a result waiting in the output register does not block the next input.
module pulse_duration_item_packer
  import pdip_pkg::*;
#(
  parameter int MAX_CHUNK_TICKS = MAX_CHUNK_TICKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [15:0] duration
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] level_first, [15:1] ticks_first, [16] level_second, [31:17] ticks_second
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  pdip_cmd_t cmd;
  pdip_sts_t sts;

  assign cfg_ready = 1'b1;

  pdip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdip_dpath #(
    .MAX_CHUNK_TICKS (MAX_CHUNK_TICKS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[sv/pdip_checker.sv]
// pdip_checker: port-level assertions for the pulse item packer, bound to the top
// depends on pdip_pkg and pulse_duration_item_packer_defines.svh
`include "pulse_duration_item_packer_defines.svh"

module pdip_checker
  import pdip_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // a stalled result transaction holds its payload
  `PDIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")

  // an accepted duration keeps the input closed through multiply and divide
  `PDIP_ASSERT_NEXT(a_in_busy, clk, rst_n, in_tvalid && in_tready,
    !in_tready ##1 !in_tready, "input reopened during scaling")

  // nothing is offered right after reset
  `PDIP_ASSERT_IMPL(a_reset_empty, clk, rst_n, $past(!rst_n),
    !out_tvalid && !in_tready, "output or input active after reset")

endmodule

bind pulse_duration_item_packer pdip_checker u_pdip_checker (.*);

[tb/sv/tb.sv]
// tb: self-checking bench for pulse_duration_item_packer (stream in, pulse items out)
// depends on pdip_pkg and the packer rtl; scoreboard predicts items from accepted durations
`timescale 1ns / 1ps

module tb;
  import pdip_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASE_ITEMS = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam longint unsigned CHUNK_MAX = MAX_CHUNK_TICKS_DEF;
  localparam longint unsigned TICK_CAP = CHUNKS_CAP * MAX_CHUNK_TICKS_DEF;

  // one pulse item, fields from the highest bit down
  typedef struct packed {
    logic               final_item;
    logic [TICKS_W-1:0] ticks_second;
    logic               level_second;
    logic [TICKS_W-1:0] ticks_first;
    logic               level_first;
  } pulse_item_t;

  // predicts pulse items from durations and checks them in order
  class pulse_item_scoreboard;
    logic [CFG_W-1:0]   ticks_per_ten_us;
    logic               half_pending;
    logic               pending_level;
    logic [TICKS_W-1:0] pending_ticks;
    pulse_item_t        expected_items[$];
    int                 error_count;

    function void reset_state();
      ticks_per_ten_us = TPT_RESET;
      half_pending = 1'b0;
      pending_level = 1'b0;
      pending_ticks = '0;
      expected_items.delete();
      error_count = 0;
    endfunction

    // one mismatch, one line, up to the first 40
    task report(input string msg);
      if (error_count < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
    endtask

    // accepted duration transaction: chunk the tick count and pair the halves
    function void note_duration(input logic [DUR_W-1:0] dur, input logic last);
      logic              lvl;
      longint unsigned   mag;
      longint unsigned   ticks;
      longint unsigned   chunk;
      pulse_item_t       item;
      pulse_item_t       step_items[$];
      lvl = ~dur[DUR_W-1];
      mag = lvl ? longint'(dur) : 65536 - longint'(dur);
      ticks = mag * longint'(ticks_per_ten_us) / 10;
      if (ticks > TICK_CAP) ticks = TICK_CAP;
      do begin
        chunk = (ticks > CHUNK_MAX) ? CHUNK_MAX : ticks;
        ticks = ticks - chunk;
        if (!half_pending) begin
          half_pending = 1'b1;
          pending_level = lvl;
          pending_ticks = chunk[TICKS_W-1:0];
        end else begin
          item = '{final_item: 1'b0, ticks_second: chunk[TICKS_W-1:0],
                   level_second: lvl, ticks_first: pending_ticks,
                   level_first: pending_level};
          step_items.insert(step_items.size(), item);
          half_pending = 1'b0;
          pending_level = 1'b0;
          pending_ticks = '0;
        end
      end while (ticks != 0);
      // odd half on the last duration gets a zero padding half
      if (last) begin
        if (half_pending) begin
          item = '{final_item: 1'b0, ticks_second: '0, level_second: 1'b0,
                   ticks_first: pending_ticks, level_first: pending_level};
          step_items.insert(step_items.size(), item);
          half_pending = 1'b0;
          pending_level = 1'b0;
          pending_ticks = '0;
        end
        if (step_items.size() > 0) step_items[step_items.size()-1].final_item = 1'b1;
      end
      foreach (step_items[i]) expected_items.insert(expected_items.size(), step_items[i]);
    endfunction

    // accepted result transaction against the oldest expected item
    task check_item(input logic [OUT_TDATA_W-1:0] tdata, input logic tlast);
      pulse_item_t got;
      pulse_item_t exp_item;
      got = {tlast, tdata};
      if (expected_items.size() == 0) begin
        report($sformatf("unexpected item tdata=%h tlast=%b", tdata, tlast));
      end else begin
        exp_item = expected_items.pop_front();
        if (got.level_first !== exp_item.level_first)
          report($sformatf("level_first %b, want %b", got.level_first, exp_item.level_first));
        if (got.ticks_first !== exp_item.ticks_first)
          report($sformatf("ticks_first %0d, want %0d", got.ticks_first, exp_item.ticks_first));
        if (got.level_second !== exp_item.level_second)
          report($sformatf("level_second %b, want %b", got.level_second,
                           exp_item.level_second));
        if (got.ticks_second !== exp_item.ticks_second)
          report($sformatf("ticks_second %0d, want %0d", got.ticks_second,
                           exp_item.ticks_second));
        if (got.final_item !== exp_item.final_item)
          report($sformatf("final_item %b, want %b", got.final_item, exp_item.final_item));
      end
    endtask

    task flag_leftovers();
      while (expected_items.size() > 0) begin
        report($sformatf("item never came: %p", expected_items.pop_front()));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;     // [15:0] duration
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  // [0] level_first, [15:1] ticks_first, [16] level_second, [31:17] ticks_second
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  pulse_item_scoreboard sb;
  int  tx_idle_pct;
  int  rx_stall_pct;
  logic rx_hold;
  int  cycle_count;

  pulse_duration_item_packer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_item(out_tdata, out_tlast);
  end

  // one duration transaction; entered and left at a falling edge
  task send_duration(input logic [DUR_W-1:0] dur, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dur;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_duration(dur, last);
    @(negedge clk);
  endtask

  // wait until every expected item is out, then let a chunk loop finish
  task drain_items();
    in_tvalid <= 1'b0;
    while (sb.expected_items.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // register write, only while the packer is idle
  task write_ticks_rate(input logic [CFG_W-1:0] value);
    drain_items();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.ticks_per_ten_us = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly short pulses, some medium, some anywhere in the 16-bit range
  function automatic logic [DUR_W-1:0] pick_duration();
    int pick;
    logic [DUR_W-1:0] mag;
    pick = $urandom_range(99);
    if (pick >= 85) return DUR_W'($urandom);
    mag = (pick < 55) ? DUR_W'($urandom_range(0, 300)) : DUR_W'($urandom_range(0, 6000));
    return $urandom_range(1) ? mag : -mag;
  endfunction

  // runs of durations closed by last, with an occasional early last
  task send_random_runs(input int n_items);
    int   run_len;
    int   run_pos;
    logic last;
    run_pos = 0;
    run_len = 1;
    for (int k = 0; k < n_items; k++) begin
      if (run_pos == 0) run_len = $urandom_range(1, 6);
      last = (run_pos == run_len - 1) || ($urandom_range(19) == 0);
      send_duration(pick_duration(), last);
      run_pos = last ? 0 : run_pos + 1;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rx_hold = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    cycle_count = 0;
    sb = new();
    sb.reset_state();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset rate, field extremes, padding and completion
    send_duration(16'sd0, 1'b0);
    send_duration(16'sd32767, 1'b0);
    send_duration(-16'sd32767, 1'b1);
    send_duration(-16'sd1, 1'b0);
    send_duration(16'sd1, 1'b1);
    send_duration(16'h8000, 1'b1);
    send_duration(16'sd5, 1'b1);
    // zero rate: every duration is one zero-tick chunk
    write_ticks_rate(10'd0);
    send_duration(16'sd32767, 1'b0);
    send_duration(16'h8000, 1'b1);
    // rate above range: tick count saturates
    write_ticks_rate(10'd1023);
    send_duration(16'h8000, 1'b1);
    send_duration(16'sd32767, 1'b0);
    send_duration(16'sd1, 1'b1);
    send_duration(16'sd12345, 1'b1);
    // top of range lands exactly on the saturation point
    write_ticks_rate(10'd800);
    send_duration(16'sd32767, 1'b1);
    send_duration(-16'sd32767, 1'b0);
    send_duration(16'sd0, 1'b1);
    // slowest rate: sub-tick pulses truncate to zero
    write_ticks_rate(10'd1);
    send_duration(-16'sd9, 1'b0);
    send_duration(16'sd10, 1'b1);

    // no idling, with a long receiver hold-off so the input backs up
    write_ticks_rate(10'($urandom_range(1, 800)));
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    send_random_runs(PHASE_ITEMS);

    // sender idles about half the time
    write_ticks_rate(10'd1);
    tx_idle_pct = 51;
    send_random_runs(PHASE_ITEMS);

    // receiver stalls about half the time
    write_ticks_rate(10'd800);
    tx_idle_pct = 0;
    rx_stall_pct = 51;
    send_random_runs(PHASE_ITEMS);

    // light idling on both sides, any register value
    write_ticks_rate(10'($urandom_range(0, 1023)));
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    send_random_runs(PHASE_ITEMS);

    drain_items();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/pdip_pkg.sv
sv/pdip_ctrl.sv
sv/pdip_dpath.sv
sv/pulse_duration_item_packer.sv
sv/pdip_checker.sv
tb/sv/tb.sv
